>>> design/vtjg_pkg.sv
`timescale 1ns / 1ps
// Package for the viewport tile job generator: sizes, field widths and
// the command/status types between controller and datapath. No dependencies.
package vtjg_pkg;

   localparam int TILE_PIXELS = 256;
   localparam int VIEW_COLS   = 320;
   localparam int VIEW_ROWS   = 240;
   localparam int JOB_LIMIT   = 9;
   localparam int ZOOM_MAX    = 18;

   localparam int FRAC_W     = 8;
   localparam int CTR_W      = 35;
   localparam int ZOOM_W     = 5;
   localparam int COORD_W    = CTR_W + 2;
   localparam int TILE_SHIFT = $clog2(TILE_PIXELS) + FRAC_W;
   localparam int IDX_W      = COORD_W - TILE_SHIFT;
   localparam int SUB_W      = TILE_SHIFT - FRAC_W + 1;
   localparam int OFS_W      = $clog2(VIEW_COLS + VIEW_ROWS + TILE_PIXELS) + 2;
   localparam int CNT_W      = $clog2(JOB_LIMIT + 1);

   localparam int COL_W = 18;
   localparam int ROW_W = 20;
   localparam int DX_W  = 9;
   localparam int DY_W  = 8;
   localparam int SRC_W = 8;
   localparam int CPY_W = 9;

   // corner offsets in 8-fraction-bit pixels
   localparam logic [COORD_W-1:0] LEFT_OFS =
      COORD_W'(VIEW_COLS * (2 ** FRAC_W) / 2);
   localparam logic [COORD_W-1:0] TOP_OFS =
      COORD_W'(VIEW_ROWS * (2 ** FRAC_W) / 2);
   localparam logic [COORD_W-1:0] RIGHT_OFS =
      COORD_W'((VIEW_COLS - 1) * (2 ** FRAC_W) - VIEW_COLS * (2 ** FRAC_W) / 2);
   localparam logic [COORD_W-1:0] BOTTOM_OFS =
      COORD_W'((VIEW_ROWS - 1) * (2 ** FRAC_W) - VIEW_ROWS * (2 ** FRAC_W) / 2);

   typedef struct packed {
      logic load;
      logic setup;
      logic emit;
      logic next_row;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic col_end;
      logic row_end;
      logic limit_hit;
      logic out_free;
   } status_type;

endpackage

>>> design/vtjg_if.sv
`timescale 1ns / 1ps
// Channel interfaces: view centre requests and tile job responses.
// Depends on vtjg_pkg.
interface vtjg_req_if;
   import vtjg_pkg::*;
   logic              valid;
   logic              ready;
   logic [CTR_W-1:0]  center_x;
   logic [CTR_W-1:0]  center_y;
   logic [ZOOM_W-1:0] zoom;

   modport source (output valid, center_x, center_y, zoom, input ready);
   modport sink (input valid, center_x, center_y, zoom, output ready);
endinterface

interface vtjg_rsp_if;
   import vtjg_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [COL_W-1:0]        tile_col;
   logic signed [ROW_W-1:0] tile_row;
   logic                    row_in_range;
   logic [DX_W-1:0]         dest_x;
   logic [DY_W-1:0]         dest_y;
   logic [SRC_W-1:0]        src_x;
   logic [SRC_W-1:0]        src_y;
   logic [CPY_W-1:0]        copy_width;
   logic [CPY_W-1:0]        copy_height;
   logic                    last;

   modport source (output valid, tile_col, tile_row, row_in_range, dest_x, dest_y,
                   src_x, src_y, copy_width, copy_height, last, input ready);
   modport sink (input valid, tile_col, tile_row, row_in_range, dest_x, dest_y,
                 src_x, src_y, copy_width, copy_height, last, output ready);
endinterface

>>> design/viewport_tile_job_generator_core.sv
`timescale 1ns / 1ps
// Viewport tile job generator: places a 320x240 view around a world-pixel centre
// and emits one copy job per covering 256-pixel map tile, row by row, left to right.
// Usage:
//   req_chan carries a view centre (x, y in unsigned fixed point, 8 fraction bits)
//   and a zoom level; zoom above 18 is taken as 18. rsp_chan returns the jobs for
//   that centre, the final one flagged by last. Every centre yields at least one job
//   and at most min(JOB_LIMIT, 6) jobs at these view and tile sizes.
// Timing:
//   A transaction on req_chan is followed by the setup state, then the walk emits
//   one job per cycle into the response register while it is empty or being read.
//   The corners are registered at the transaction and the cursors in setup, before
//   the first job. req_chan.ready is high only while idle, and the next centre is
//   accepted while the final job still waits in the response register.
// Stalls:
//   While a waiting job is not taken, the walk holds on its tile; no job is lost.
// Reset:
//   Synchronous, active high; returns to idle with no response pending.
module viewport_tile_job_generator_core (
   input  logic       clock,
   input  logic       reset,
   vtjg_req_if.sink   req_chan,
   vtjg_rsp_if.source rsp_chan
);
   import vtjg_pkg::*;

   cmd_type    cmd;
   status_type status;

   vtjg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   vtjg_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_center_x (req_chan.center_x),
      .req_center_y (req_chan.center_y),
      .req_zoom     (req_chan.zoom),
      .cmd          (cmd),
      .status       (status),
      .rsp_chan     (rsp_chan)
   );

`ifndef SYNTH
   a_emit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("job emitted into an occupied response register");

   a_accept_then_setup: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> cmd.setup)
      else $error("accepted transaction not followed by setup");

   a_last_frees_input: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> req_chan.ready)
      else $error("input not ready after final job");

   a_job_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.copy_width != 0 && rsp_chan.copy_height != 0))
      else $error("job with empty copy area");
`endif

endmodule

>>> design/vtjg_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, setup and the tile walk.
// Depends on vtjg_pkg.
module vtjg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  vtjg_pkg::status_type status,
   output vtjg_pkg::cmd_type    cmd
);
   import vtjg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      cmd          = '0;
      cmd.load     = (state_ff == ST_IDLE) && req_valid && req_ready_ff;
      cmd.setup    = (state_ff == ST_SETUP);
      cmd.emit     = (state_ff == ST_WALK) && status.out_free;
      cmd.next_row = status.col_end;
      cmd.last     = (status.col_end && status.row_end) || status.limit_hit;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.load) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (cmd.emit && cmd.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

>>> design/vtjg_datapath.sv
`timescale 1ns / 1ps
// Datapath: viewport corners, tile cursors, clipping and the response register.
// Depends on vtjg_pkg and vtjg_rsp_if.
module vtjg_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [vtjg_pkg::CTR_W-1:0]  req_center_x,
   input  logic [vtjg_pkg::CTR_W-1:0]  req_center_y,
   input  logic [vtjg_pkg::ZOOM_W-1:0] req_zoom,
   input  vtjg_pkg::cmd_type           cmd,
   output vtjg_pkg::status_type        status,
   vtjg_rsp_if.source                  rsp_chan
);
   import vtjg_pkg::*;

   localparam logic [SUB_W-1:0] SUB_FULL = SUB_W'(2 ** (TILE_SHIFT - FRAC_W));
   localparam logic signed [OFS_W-1:0] TILE_OFS = OFS_W'(TILE_PIXELS);
   localparam logic signed [OFS_W-1:0] COLS_OFS = OFS_W'(VIEW_COLS);
   localparam logic signed [OFS_W-1:0] ROWS_OFS = OFS_W'(VIEW_ROWS);

   // view corners
   logic [ZOOM_W-1:0]  zoom_ff;
   logic [COORD_W-1:0] left_ff, top_ff, right_ff, bottom_ff;

   // walk cursors
   logic signed [IDX_W-1:0] col_first_ff, col_last_ff, row_last_ff;
   logic signed [IDX_W-1:0] tx_ff, ty_ff;
   logic signed [OFS_W-1:0] dx0_ff, dx_ff, dy_ff;
   logic [CNT_W-1:0]        cnt_ff;

   // response register
   logic                    rsp_valid_ff;
   logic [COL_W-1:0]        col_ff;
   logic signed [ROW_W-1:0] row_ff;
   logic                    in_range_ff;
   logic [DX_W-1:0]         dest_x_ff;
   logic [DY_W-1:0]         dest_y_ff;
   logic [SRC_W-1:0]        src_x_ff, src_y_ff;
   logic [CPY_W-1:0]        width_ff, height_ff;
   logic                    last_ff;

   // setup: partial pixel into the first tile, rounded up
   logic [TILE_SHIFT:0]     lx_sum, ly_sum;
   logic [SUB_W-1:0]        bx, by;
   logic                    x_full, y_full;
   logic signed [IDX_W-1:0] col_first, row_first;

   // clipping of the current tile
   logic                    dx_neg, dy_neg;
   logic signed [OFS_W-1:0] sx, sy, dxc, dyc, w_a, w_b, h_a, h_b, w, h;
   logic [COL_W-1:0]        col_mask;
   logic                    row_ok;

   assign lx_sum = {1'b0, left_ff[TILE_SHIFT-1:0]} + (TILE_SHIFT + 1)'(2 ** FRAC_W - 1);
   assign ly_sum = {1'b0, top_ff[TILE_SHIFT-1:0]} + (TILE_SHIFT + 1)'(2 ** FRAC_W - 1);
   assign bx     = lx_sum[TILE_SHIFT:FRAC_W];
   assign by     = ly_sum[TILE_SHIFT:FRAC_W];
   assign x_full = (bx == SUB_FULL);
   assign y_full = (by == SUB_FULL);
   // an empty first column or row is skipped
   assign col_first = $signed(left_ff[COORD_W-1:TILE_SHIFT]) + IDX_W'(x_full);
   assign row_first = $signed(top_ff[COORD_W-1:TILE_SHIFT]) + IDX_W'(y_full);

   assign dx_neg = dx_ff[OFS_W-1];
   assign dy_neg = dy_ff[OFS_W-1];
   assign sx     = dx_neg ? -dx_ff : '0;
   assign sy     = dy_neg ? -dy_ff : '0;
   assign dxc    = dx_neg ? '0 : dx_ff;
   assign dyc    = dy_neg ? '0 : dy_ff;
   assign w_a    = TILE_OFS - sx;
   assign w_b    = COLS_OFS - dxc;
   assign h_a    = TILE_OFS - sy;
   assign h_b    = ROWS_OFS - dyc;
   assign w      = (w_a < w_b) ? w_a : w_b;
   assign h      = (h_a < h_b) ? h_a : h_b;

   assign col_mask = ~({COL_W{1'b1}} << zoom_ff);
   assign row_ok   = !ty_ff[IDX_W-1] && ((ty_ff[IDX_W-2:0] >> zoom_ff) == '0);

   always_comb begin
      status           = '0;
      status.col_end   = (tx_ff == col_last_ff);
      status.row_end   = (ty_ff == row_last_ff);
      status.limit_hit = (cnt_ff == CNT_W'(JOB_LIMIT - 1));
      status.out_free  = !rsp_valid_ff || rsp_chan.ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zoom_ff   <= (req_zoom > ZOOM_W'(ZOOM_MAX)) ? ZOOM_W'(ZOOM_MAX) : req_zoom;
         left_ff   <= {2'b00, req_center_x} - LEFT_OFS;
         top_ff    <= {2'b00, req_center_y} - TOP_OFS;
         right_ff  <= {2'b00, req_center_x} + RIGHT_OFS;
         bottom_ff <= {2'b00, req_center_y} + BOTTOM_OFS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.setup) begin
         cnt_ff <= '0;
      end else if (cmd.emit) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         col_first_ff <= col_first;
         col_last_ff  <= $signed(right_ff[COORD_W-1:TILE_SHIFT]);
         row_last_ff  <= $signed(bottom_ff[COORD_W-1:TILE_SHIFT]);
         tx_ff        <= col_first;
         ty_ff        <= row_first;
         dx0_ff       <= x_full ? '0 : -OFS_W'(bx);
         dx_ff        <= x_full ? '0 : -OFS_W'(bx);
         dy_ff        <= y_full ? '0 : -OFS_W'(by);
      end else if (cmd.emit && !cmd.last) begin
         if (cmd.next_row) begin
            tx_ff <= col_first_ff;
            dx_ff <= dx0_ff;
            ty_ff <= ty_ff + IDX_W'(1);
            dy_ff <= dy_ff + TILE_OFS;
         end else begin
            tx_ff <= tx_ff + IDX_W'(1);
            dx_ff <= dx_ff + TILE_OFS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         col_ff      <= tx_ff[COL_W-1:0] & col_mask;
         row_ff      <= ty_ff[ROW_W-1:0];
         in_range_ff <= row_ok;
         dest_x_ff   <= dxc[DX_W-1:0];
         dest_y_ff   <= dyc[DY_W-1:0];
         src_x_ff    <= sx[SRC_W-1:0];
         src_y_ff    <= sy[SRC_W-1:0];
         width_ff    <= w[CPY_W-1:0];
         height_ff   <= h[CPY_W-1:0];
         last_ff     <= cmd.last;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.tile_col     = col_ff;
   assign rsp_chan.tile_row     = row_ff;
   assign rsp_chan.row_in_range = in_range_ff;
   assign rsp_chan.dest_x       = dest_x_ff;
   assign rsp_chan.dest_y       = dest_y_ff;
   assign rsp_chan.src_x        = src_x_ff;
   assign rsp_chan.src_y        = src_y_ff;
   assign rsp_chan.copy_width   = width_ff;
   assign rsp_chan.copy_height  = height_ff;
   assign rsp_chan.last         = last_ff;

endmodule

>>> test/viewport_tile_job_generator_core_tb.sv
`timescale 1ns / 1ps
// Testbench for viewport_tile_job_generator_core: drives view centres, predicts the tile
// copy jobs of each one and checks every job field by field, with random idling on both sides.
// Depends on vtjg_pkg, vtjg_if.sv and the core.
module viewport_tile_job_generator_core_tb;
   import vtjg_pkg::*;

   localparam int QUIET_LIMIT = 4000;

   typedef struct packed {
      logic [COL_W-1:0] tile_col;
      logic [ROW_W-1:0] tile_row;
      logic             row_in_range;
      logic [DX_W-1:0]  dest_x;
      logic [DY_W-1:0]  dest_y;
      logic [SRC_W-1:0] src_x;
      logic [SRC_W-1:0] src_y;
      logic [CPY_W-1:0] copy_width;
      logic [CPY_W-1:0] copy_height;
      logic             last;
   } tile_job_type;

   class tile_job_scoreboard;
      tile_job_type pending_jobs[$];
      int           errors;
      int           views;
      int           jobs_checked;
      int           rows_outside;
      int           cols_wrapped;
      int           zooms_clamped;

      function int pending();
         return pending_jobs.size();
      endfunction

      // expected jobs for one accepted view centre
      function void note_view(logic [CTR_W-1:0] cx, logic [CTR_W-1:0] cy,
                              logic [ZOOM_W-1:0] zoom_in);
         longint       left, top, right, bottom, tiles;
         longint       col0, col1, row0, row1, dx, dy, sx, sy, w, h;
         int           z;
         tile_job_type job;
         tile_job_type batch[$];
         views++;
         z = zoom_in;
         if (z > ZOOM_MAX) begin
            z = ZOOM_MAX;
            zooms_clamped++;
         end
         tiles  = longint'(1) << z;
         left   = longint'(cx) - VIEW_COLS * 128;
         top    = longint'(cy) - VIEW_ROWS * 128;
         right  = left + (VIEW_COLS - 1) * 256;
         bottom = top + (VIEW_ROWS - 1) * 256;
         col0   = left >>> TILE_SHIFT;
         col1   = right >>> TILE_SHIFT;
         row0   = top >>> TILE_SHIFT;
         row1   = bottom >>> TILE_SHIFT;
         for (longint ty = row0; ty <= row1 && batch.size() < JOB_LIMIT; ty++) begin
            for (longint tx = col0; tx <= col1 && batch.size() < JOB_LIMIT; tx++) begin
               dx = ((tx << TILE_SHIFT) - left) >>> FRAC_W;
               dy = ((ty << TILE_SHIFT) - top) >>> FRAC_W;
               sx = 0;
               sy = 0;
               if (dx < 0) begin
                  sx = -dx;
                  dx = 0;
               end
               if (dy < 0) begin
                  sy = -dy;
                  dy = 0;
               end
               w = TILE_PIXELS - sx;
               if (VIEW_COLS - dx < w) w = VIEW_COLS - dx;
               h = TILE_PIXELS - sy;
               if (VIEW_ROWS - dy < h) h = VIEW_ROWS - dy;
               if (w <= 0 || h <= 0) continue;
               job.tile_col     = COL_W'(tx & (tiles - 1));
               job.tile_row     = ROW_W'(ty);
               job.row_in_range = (ty >= 0 && ty < tiles);
               job.dest_x       = DX_W'(dx);
               job.dest_y       = DY_W'(dy);
               job.src_x        = SRC_W'(sx);
               job.src_y        = SRC_W'(sy);
               job.copy_width   = CPY_W'(w);
               job.copy_height  = CPY_W'(h);
               job.last         = 1'b0;
               if (!job.row_in_range) rows_outside++;
               if (tx < 0 || tx >= tiles) cols_wrapped++;
               batch.push_back(job);
            end
         end
         foreach (batch[i]) begin
            job = batch[i];
            job.last = (i == batch.size() - 1);
            pending_jobs.push_back(job);
         end
      endfunction

      function void match(string field, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
         if (got !== want) begin
            $error("job field %s: expected %0h, got %0h", field, want, got);
            errors++;
         end
      endfunction

      function void check_job(tile_job_type got);
         tile_job_type want;
         if (pending_jobs.size() == 0) begin
            $error("tile job with none expected: col %0h row %0h",
                   got.tile_col, got.tile_row);
            errors++;
            return;
         end
         want = pending_jobs.pop_front();
         jobs_checked++;
         match("tile_col", want.tile_col, got.tile_col);
         match("tile_row", want.tile_row, got.tile_row);
         match("row_in_range", want.row_in_range, got.row_in_range);
         match("dest_x", want.dest_x, got.dest_x);
         match("dest_y", want.dest_y, got.dest_y);
         match("src_x", want.src_x, got.src_x);
         match("src_y", want.src_y, got.src_y);
         match("copy_width", want.copy_width, got.copy_width);
         match("copy_height", want.copy_height, got.copy_height);
         match("last", want.last, got.last);
      endfunction
   endclass

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_stall_pct;
   int   quiet_cycles;
   tile_job_scoreboard sb;

   vtjg_req_if req_chan ();
   vtjg_rsp_if rsp_chan ();

   viewport_tile_job_generator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         quiet_cycles   <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_job('{tile_col: rsp_chan.tile_col, tile_row: rsp_chan.tile_row,
                           row_in_range: rsp_chan.row_in_range, dest_x: rsp_chan.dest_x,
                           dest_y: rsp_chan.dest_y, src_x: rsp_chan.src_x,
                           src_y: rsp_chan.src_y, copy_width: rsp_chan.copy_width,
                           copy_height: rsp_chan.copy_height, last: rsp_chan.last});
         rsp_chan.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
         if ((rsp_chan.valid && rsp_chan.ready) || (req_chan.valid && req_chan.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_view(input logic [CTR_W-1:0] cx, input logic [CTR_W-1:0] cy,
                            input logic [ZOOM_W-1:0] zoom);
      while ($urandom_range(99, 0) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.center_x <= cx;
      req_chan.center_y <= cy;
      req_chan.zoom     <= zoom;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_view(cx, cy, zoom);
   endtask

   // hold off new centres until every job of the earlier ones is back
   task automatic drain_jobs();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [CTR_W-1:0] rand_coord();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      case ($urandom_range(3, 0))
         0: return raw[CTR_W-1:0];
         1: return CTR_W'($urandom_range(1 << 20, 0));
         2: return CTR_W'({raw[CTR_W-1:TILE_SHIFT], 16'h0} + $urandom_range(65535, 0));
         default: return ~CTR_W'($urandom_range(1 << 20, 0));
      endcase
   endfunction

   initial begin
      sb                = new();
      reset             = 1'b1;
      req_idle_pct      = 0;
      rsp_stall_pct     = 0;
      req_chan.valid    = 1'b0;
      req_chan.center_x = '0;
      req_chan.center_y = '0;
      req_chan.zoom     = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_view('0, '0, 5'd0);
      send_view('1, '1, 5'd31);
      send_view(CTR_W'(160 << 8), CTR_W'(120 << 8), 5'd0);
      send_view(CTR_W'((160 << 8) + 128), CTR_W'((120 << 8) + 255), 5'd1);
      send_view(CTR_W'((160 << 8) | 255), CTR_W'((120 << 8) | 1), 5'd2);
      send_view(CTR_W'(1) << 34, CTR_W'(1) << 34, 5'd18);
      send_view(CTR_W'(1) << 34, CTR_W'(1) << 34, 5'd19);
      send_view(CTR_W'(100 << 8), CTR_W'(50 << 8), 5'd3);
      send_view(CTR_W'(300 << 8), CTR_W'(2 << 16), 5'd1);
      send_view(CTR_W'(1 << 16), CTR_W'(1 << 16), 5'd1);
      send_view('1, '0, 5'd5);
      send_view('0, '1, 5'd18);
      send_view(CTR_W'(((256 + 160) << 8) - 1), CTR_W'(((256 + 120) << 8) + 1), 5'd9);
      send_view(35'h555555555, 35'h2AAAAAAAA, 5'd10);
      send_view(35'h2AAAAAAAA, 35'h555555555, 5'd21);
      send_view(CTR_W'(200 << 8), CTR_W'(100 << 8), 5'd16);
      send_view(CTR_W'((1 << 24) + 77), CTR_W'((1 << 24) - 77), 5'd17);
      send_view(CTR_W'(1) << 33, CTR_W'(3) << 32, 5'd31);
      drain_jobs();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 51; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 51; end
            default: begin req_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         repeat (28) begin
            send_view(rand_coord(), rand_coord(),
                      ($urandom_range(3, 0) == 0) ? ZOOM_W'($urandom_range(31, 0))
                                                   : ZOOM_W'($urandom_range(18, 0)));
            if ($urandom_range(19, 0) == 0) drain_jobs();
         end
         drain_jobs();
      end

      rsp_stall_pct = 0;
      repeat (20) @(posedge clock);
      $display("Covered %0d view centres and %0d jobs: %0d rows outside the world,",
               sb.views, sb.jobs_checked, sb.rows_outside);
      $display("%0d wrapped columns, %0d zooms clamped, %0d jobs still pending.",
               sb.cols_wrapped, sb.zooms_clamped, sb.pending());
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> files.f
design/vtjg_pkg.sv
design/vtjg_if.sv
design/vtjg_ctrl.sv
design/vtjg_datapath.sv
design/viewport_tile_job_generator_core.sv
test/viewport_tile_job_generator_core_tb.sv
